// ===== sv/assert_macros.svh =====
// Assertion macros used by the palette search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Check that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed: expected consequence missing");

`endif

// ===== sv/nps_pkg.sv =====
// Package with types and constants of the nearest palette color search.
package nps_pkg;

    localparam int PALETTE_DEPTH = 512;
    localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = ($clog2(PALETTE_DEPTH + 1) > 10) ?
                                   $clog2(PALETTE_DEPTH + 1) : 10;
    localparam int DIST_W        = 18;
    localparam int ENTRY_W       = 40;

    localparam logic [DIST_W-1:0] START_MIN          = DIST_W'(255 * 3 * 255);
    localparam logic [9:0]        RESET_ENTRIES_USED = 10'd376;

    localparam logic [1:0] METRIC_SAD = 2'd0;
    localparam logic [1:0] METRIC_MAX = 2'd1;
    localparam logic [1:0] METRIC_SSQ = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_METRIC  = 1'b0;
    localparam logic CFG_ENTRIES = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t       color;
        logic [7:0] attribute;
        logic [7:0] glyph;
    } entry_t;

    typedef struct packed {
        logic       req_type;
        logic [8:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] attribute_in;
        logic [7:0] glyph_in;
    } req_t;

    typedef struct packed {
        logic [8:0] match_index;
        logic [7:0] match_red;
        logic [7:0] match_green;
        logic [7:0] match_blue;
        logic [7:0] match_attribute;
        logic [7:0] match_glyph;
    } rsp_t;

    // Valid flag and entry index that travel with a distance through the pipeline
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] index;
    } tag_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_LOAD
    } state_t;

endpackage

// ===== sv/nps_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, registered read on enable; read data holds while idle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nps_dist.sv =====
// Two-stage color distance pipeline: absolute differences, then the metric.
module nps_dist (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    metric_mode,
    input  nps_pkg::rgb_t query,
    input  nps_pkg::rgb_t entry_color,
    input  nps_pkg::tag_t tag_in,
    output logic [nps_pkg::DIST_W-1:0] dist_out,
    output nps_pkg::tag_t tag_out
);
    import nps_pkg::*;

    logic [7:0]        dr_next, dg_next, db_next;
    logic [7:0]        dr_reg, dg_reg, db_reg;
    logic              v1_reg, v2_reg;
    logic [ADDR_W-1:0] idx1_reg, idx2_reg;
    logic [DIST_W-1:0] dist_next, dist_reg;
    logic [15:0]       sq_r, sq_g, sq_b;
    logic [7:0]        max_rg;

    // Take absolute differences per component
    always_comb
    begin
        dr_next = (query.red   > entry_color.red)   ? query.red   - entry_color.red
                                                    : entry_color.red   - query.red;
        dg_next = (query.green > entry_color.green) ? query.green - entry_color.green
                                                    : entry_color.green - query.green;
        db_next = (query.blue  > entry_color.blue)  ? query.blue  - entry_color.blue
                                                    : entry_color.blue  - query.blue;
    end

    // Combine the differences under the selected metric; code three acts as squares
    always_comb
    begin
        sq_r      = dr_reg * dr_reg;
        sq_g      = dg_reg * dg_reg;
        sq_b      = db_reg * db_reg;
        max_rg    = (dg_reg > dr_reg) ? dg_reg : dr_reg;
        dist_next = '0;
        case (metric_mode)
            METRIC_SAD:
            begin
                dist_next = DIST_W'(dr_reg) + DIST_W'(dg_reg) + DIST_W'(db_reg);
            end
            METRIC_MAX:
            begin
                dist_next = DIST_W'((db_reg > max_rg) ? db_reg : max_rg);
            end
            default:
            begin
                dist_next = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
            end
        endcase
    end

    // Advance the payload stages
    always_ff @(posedge clk)
    begin
        dr_reg   <= dr_next;
        dg_reg   <= dg_next;
        db_reg   <= db_next;
        dist_reg <= dist_next;
        idx1_reg <= tag_in.index;
        idx2_reg <= idx1_reg;
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= tag_in.valid;
            v2_reg <= v1_reg;
        end
    end

    assign dist_out = dist_reg;
    assign tag_out  = '{valid: v2_reg, index: idx2_reg};

endmodule

// ===== sv/nearest_palette_color_search.sv =====
// A query steps through scan, drain, fetch and load; an empty scan goes straight to fetch.
// Throughput: one query at a time, one palette entry read and compared per cycle while
// scanning, set by the single read port; palette writes are taken only while idle.
// The next item is accepted while a finished result waits in the output register.
// Reset clears control state and sets metric_mode to 0 and entries_used to 376;
// the palette RAM is not cleared and an entry must be written before it is matched.
`include "assert_macros.svh"

module nearest_palette_color_search (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  nps_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output nps_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [9:0]    cfg_data
);
    import nps_pkg::*;

    state_t              state_reg, state_next;
    logic [1:0]          metric_mode_reg;
    logic [9:0]          entries_used_reg;
    rgb_t                query_reg;
    logic [ADDR_W-1:0]   issue_reg, issue_next;
    logic [ADDR_W-1:0]   last_reg;
    logic [ADDR_W-1:0]   best_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic                rdv_reg;
    logic [ADDR_W-1:0]   rdidx_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic                dist_stage1_valid_reg;

    logic                req_fire;
    logic                wr_fire;
    logic                query_fire;
    logic [CNT_W-1:0]    eu_ext;
    logic [CNT_W-1:0]    count;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    entry_t              wr_entry;
    entry_t              rd_entry;
    logic                rsp_free;
    tag_t                tag_in;
    tag_t                tag_out;
    logic [DIST_W-1:0]   cand_dist;
    logic                scan_busy;

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign query_fire = req_fire && (req.req_type == REQ_QUERY);
    assign wr_fire    = req_fire && (req.req_type == REQ_WRITE);
    assign cfg_ready  = 1'b1;
    assign rsp_free   = !rsp_valid_reg || rsp_ready;

    // Saturate the scan length to the palette depth
    always_comb
    begin
        eu_ext = CNT_W'(entries_used_reg);
        count  = (eu_ext > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : eu_ext;
    end

    // Drop writes beyond the palette; writes happen only while idle, reads never do
    assign ram_we = wr_fire && (CNT_W'(req.entry_index) < CNT_W'(PALETTE_DEPTH));
    assign wr_entry.color.red   = req.red;
    assign wr_entry.color.green = req.green;
    assign wr_entry.color.blue  = req.blue;
    assign wr_entry.attribute   = req.attribute_in;
    assign wr_entry.glyph       = req.glyph_in;

    nps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(req.entry_index)),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    assign tag_in.valid = rdv_reg;
    assign tag_in.index = rdidx_reg;

    nps_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .metric_mode (metric_mode_reg),
        .query       (query_reg),
        .entry_color (rd_entry.color),
        .tag_in      (tag_in),
        .dist_out    (cand_dist),
        .tag_out     (tag_out)
    );

    // Any read or distance still on its way to the compare
    assign scan_busy = rdv_reg || dist_stage1_valid_reg || tag_out.valid;

    // Sequence the scan, the drain, the final fetch and the result load
    always_comb
    begin
        state_next = state_reg;
        issue_next = issue_reg;
        ram_re     = 1'b0;
        ram_raddr  = issue_reg;
        case (state_reg)
            ST_IDLE:
            begin
                issue_next = '0;
                if (query_fire)
                begin
                    state_next = (count == '0) ? ST_FETCH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_re     = 1'b1;
                issue_next = issue_reg + 1'b1;
                if (issue_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!scan_busy)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                ram_re     = 1'b1;
                ram_raddr  = best_reg;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            rdv_reg               <= 1'b0;
            dist_stage1_valid_reg <= 1'b0;
            rsp_valid_reg         <= 1'b0;
            metric_mode_reg       <= METRIC_SAD;
            entries_used_reg      <= RESET_ENTRIES_USED;
        end
        else
        begin
            state_reg             <= state_next;
            rdv_reg               <= (state_reg == ST_SCAN);
            dist_stage1_valid_reg <= rdv_reg;
            if (state_reg == ST_LOAD && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_METRIC:  metric_mode_reg  <= cfg_data[1:0];
                    CFG_ENTRIES: entries_used_reg <= cfg_data;
                    default:     entries_used_reg <= entries_used_reg;
                endcase
            end
        end
    end

    // Hold the query, scan bounds, running minimum and the result
    always_ff @(posedge clk)
    begin
        issue_reg <= issue_next;
        rdidx_reg <= issue_reg;
        if (query_fire)
        begin
            query_reg.red   <= req.red;
            query_reg.green <= req.green;
            query_reg.blue  <= req.blue;
            last_reg        <= ADDR_W'(count - 1'b1);
            best_reg        <= '0;
            best_dist_reg   <= START_MIN;
        end
        else if (tag_out.valid && (cand_dist < best_dist_reg))
        begin
            best_reg      <= tag_out.index;
            best_dist_reg <= cand_dist;
        end
        if (state_reg == ST_LOAD && rsp_free)
        begin
            rsp_reg.match_index     <= 9'(best_reg);
            rsp_reg.match_red       <= rd_entry.color.red;
            rsp_reg.match_green     <= rd_entry.color.green;
            rsp_reg.match_blue      <= rd_entry.color.blue;
            rsp_reg.match_attribute <= rd_entry.attribute;
            rsp_reg.match_glyph     <= rd_entry.glyph;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_fetch_after_drain, (state_reg != ST_FETCH) || (!rdv_reg && !tag_out.valid))
    `ASSERT_ALWAYS(a_min_bounded, (state_reg == ST_IDLE) || (best_dist_reg <= START_MIN))
    `ASSERT_NEXT(a_query_leaves_idle, query_fire, state_reg != ST_IDLE)
    `ASSERT_ALWAYS(a_scan_in_range, (state_reg != ST_SCAN) || (CNT_W'(issue_reg) < count))

endmodule

// ===== tb/palette_match_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts and compares nearest palette color results.
module palette_match_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  nps_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  nps_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [9:0]    cfg_data,
    output int            awaiting,
    output int            failures
);
    import nps_pkg::*;

    // Shadow copy of the palette and the registers
    entry_t      palette_table [PALETTE_DEPTH];
    logic [1:0]  metric_sel = METRIC_SAD;
    logic [9:0]  scan_count = RESET_ENTRIES_USED;

    // Expected matches, oldest first
    rsp_t        pending_matches [$];
    rsp_t        want;
    int          fail_total = 0;
    int          slot;

    // Distance between two colors under the given metric
    function automatic logic [17:0] metric_distance(rgb_t a, rgb_t b, logic [1:0] mode);
        logic [17:0] dr;
        logic [17:0] dg;
        logic [17:0] db;
        logic [17:0] peak;
        dr = (a.red   > b.red)   ? 18'(a.red   - b.red)   : 18'(b.red   - a.red);
        dg = (a.green > b.green) ? 18'(a.green - b.green) : 18'(b.green - a.green);
        db = (a.blue  > b.blue)  ? 18'(a.blue  - b.blue)  : 18'(b.blue  - a.blue);
        case (mode)
            METRIC_SAD:
                return dr + dg + db;
            METRIC_MAX:
            begin
                peak = dr;
                if (dg > peak)
                    peak = dg;
                if (db > peak)
                    peak = db;
                return peak;
            end
            default:
                return dr * dr + dg * dg + db * db;
        endcase
    endfunction

    // Scan the entries in use; only a strictly closer entry replaces the best
    function automatic rsp_t nearest_entry(rgb_t probe);
        int          span;
        int          idx;
        int          best;
        logic [17:0] best_dist;
        logic [17:0] cand_dist;
        rsp_t        hit;
        span      = (scan_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(scan_count);
        best      = 0;
        best_dist = START_MIN;
        for (idx = 0; idx < span; idx++)
        begin
            cand_dist = metric_distance(probe, palette_table[idx].color, metric_sel);
            if (cand_dist < best_dist)
            begin
                best_dist = cand_dist;
                best      = idx;
            end
        end
        hit.match_index     = 9'(best);
        hit.match_red       = palette_table[best].color.red;
        hit.match_green     = palette_table[best].color.green;
        hit.match_blue      = palette_table[best].color.blue;
        hit.match_attribute = palette_table[best].attribute;
        hit.match_glyph     = palette_table[best].glyph;
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (slot = 0; slot < PALETTE_DEPTH; slot++)
                palette_table[slot] = '0;
            metric_sel = METRIC_SAD;
            scan_count = RESET_ENTRIES_USED;
            pending_matches.delete();
            awaiting <= 0;
            failures <= fail_total;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_METRIC)
                    metric_sel = cfg_data[1:0];
                else
                    scan_count = cfg_data;
            end

            // Store a written entry or predict the match of a query
            if (req_valid && req_ready)
            begin
                if (req.req_type == REQ_WRITE)
                begin
                    palette_table[req.entry_index].color     = {req.red, req.green, req.blue};
                    palette_table[req.entry_index].attribute = req.attribute_in;
                    palette_table[req.entry_index].glyph     = req.glyph_in;
                end
                else
                    pending_matches.insert(pending_matches.size(),
                                           nearest_entry({req.red, req.green, req.blue}));
            end

            // Compare each accepted result with the oldest expectation
            if (rsp_valid && rsp_ready)
            begin
                if (pending_matches.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result with no query waiting, index %0d",
                                 $realtime, rsp.match_index);
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (rsp.match_index !== want.match_index ||
                        rsp.match_red !== want.match_red ||
                        rsp.match_green !== want.match_green ||
                        rsp.match_blue !== want.match_blue ||
                        rsp.match_attribute !== want.match_attribute ||
                        rsp.match_glyph !== want.match_glyph)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $display("%0t: match mismatch: index exp %0d got %0d",
                                     $realtime, want.match_index, rsp.match_index);
                            $display("    rgb exp %h%h%h got %h%h%h",
                                     want.match_red, want.match_green, want.match_blue,
                                     rsp.match_red, rsp.match_green, rsp.match_blue);
                            $display("    attr exp %h got %h, glyph exp %h got %h",
                                     want.match_attribute, rsp.match_attribute,
                                     want.match_glyph, rsp.match_glyph);
                        end
                    end
                end
            end

            awaiting <= pending_matches.size();
            failures <= fail_total;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the nearest palette color search testbench: clock, reset, stimulus and verdict.
module testbench;
    import nps_pkg::*;

    localparam logic [1:0] METRIC_SPARE = 2'd3;
    localparam int         CYCLE_LIMIT  = 4_000_000;
    localparam int         PHASES       = 9;
    localparam int         REQ_W        = $bits(req_t);

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = CFG_METRIC;
    logic [9:0] cfg_data  = '0;

    int         awaiting;
    int         failures;
    int         cycle_count = 0;
    bit         steady = 1'b0;
    rgb_t       color_pool [4];

    // Settings of the random phases, mostly small scans
    logic [1:0] phase_metric [PHASES] = '{METRIC_SAD, METRIC_MAX, METRIC_SSQ, METRIC_SPARE,
                                          METRIC_SAD, METRIC_MAX, METRIC_SSQ, METRIC_SAD,
                                          METRIC_MAX};
    logic [9:0] phase_count  [PHASES] = '{10'd1, 10'd2, 10'd7, 10'd16, 10'd33, 10'd64,
                                          10'd376, 10'd512, 10'd1023};
    int         phase_items  [PHASES] = '{50, 50, 50, 50, 50, 50, 40, 30, 30};

    always #5 clk = ~clk;

    nearest_palette_color_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    palette_match_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .awaiting  (awaiting),
        .failures  (failures)
    );

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Shift a component by a few steps, clamped to the byte range
    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    // Pool colors, near-pool colors, corners and fully random colors
    function automatic rgb_t random_color();
        rgb_t base;
        int   roll;
        roll = $urandom_range(0, 99);
        base = color_pool[$urandom_range(0, 3)];
        if (roll < 30)
            return base;
        if (roll < 45)
            return {nudge(base.red), nudge(base.green), nudge(base.blue)};
        if (roll < 55)
            return {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                    $urandom_range(0, 1) ? 8'hFF : 8'h00,
                    $urandom_range(0, 1) ? 8'hFF : 8'h00};
        return 24'($urandom);
    endfunction

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(input req_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic store_entry(input logic [8:0] idx, input rgb_t color,
                               input logic [7:0] attr, input logic [7:0] glyph);
        req_t item;
        item.req_type     = REQ_WRITE;
        item.entry_index  = idx;
        item.red          = color.red;
        item.green        = color.green;
        item.blue         = color.blue;
        item.attribute_in = attr;
        item.glyph_in     = glyph;
        send_item(item);
    endtask

    // Unused fields of a query carry random values
    task automatic ask_nearest(input rgb_t color);
        req_t item;
        item              = REQ_W'({$urandom, $urandom});
        item.req_type     = REQ_QUERY;
        item.red          = color.red;
        item.green        = color.green;
        item.blue         = color.blue;
        send_item(item);
    endtask

    // Drop valid and wait until every expected match has come back
    task automatic hold_until_empty();
        req_valid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Reconfigure only with the block idle; upper metric bits are don't-care
    task automatic apply_setting(input logic [1:0] metric, input logic [9:0] count);
        hold_until_empty();
        repeat (8) @(posedge clk);
        write_reg(CFG_METRIC, {8'($urandom), metric});
        write_reg(CFG_ENTRIES, count);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: ready runs, sometimes long, broken by random stalls
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            rsp_ready <= 1'b1;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 24)) @(posedge clk);
            if (!steady)
            begin
                rsp_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int step;
        int span;
        int k;

        for (k = 0; k < 4; k++)
            color_pool[k] = 24'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole palette so that no scan reads an unwritten entry
        for (k = 0; k < PALETTE_DEPTH; k++)
            store_entry(9'(k), random_color(), 8'($urandom), 8'($urandom));

        // Ties go to the lowest index; the top entry lies outside the scan
        apply_setting(METRIC_SAD, 10'd4);
        store_entry(9'd0, 24'hFFFFFF, 8'h00, 8'hFF);
        store_entry(9'd1, 24'h000000, 8'hFF, 8'h00);
        store_entry(9'd2, 24'h000000, 8'h5A, 8'hA5);
        store_entry(9'd3, 24'h804020, 8'h81, 8'h7E);
        store_entry(9'h1FF, 24'h0180FE, 8'hFF, 8'hFF);
        ask_nearest(24'h000000);
        ask_nearest(24'hFFFFFF);
        ask_nearest(24'h823C1E);

        // Farthest distance equals the starting minimum: entry 0 stays
        apply_setting(METRIC_SSQ, 10'd4);
        store_entry(9'd1, 24'hFFFFFF, 8'h11, 8'h22);
        store_entry(9'd2, 24'hFFFFFF, 8'h33, 8'h44);
        store_entry(9'd3, 24'hFFFFFF, 8'h55, 8'h66);
        ask_nearest(24'h000000);

        // Spare metric code with an empty scan
        apply_setting(METRIC_SPARE, 10'd0);
        ask_nearest(24'h112233);

        // Scan lengths above the palette depth saturate
        apply_setting(METRIC_MAX, 10'd1023);
        ask_nearest(24'hFF00FF);
        ask_nearest(24'h00FF00);
        apply_setting(METRIC_SSQ, 10'd513);
        ask_nearest(24'h010203);

        // Random phases: writes mostly land inside the scanned range
        for (phase = 0; phase < PHASES; phase++)
        begin
            apply_setting(phase_metric[phase], phase_count[phase]);
            steady = (phase == 1 || phase == 6);
            for (k = 0; k < 4; k++)
                color_pool[k] = 24'($urandom);
            span = (phase_count[phase] == 0) ? 1 :
                   (phase_count[phase] > PALETTE_DEPTH) ? PALETTE_DEPTH :
                   int'(phase_count[phase]);
            for (step = 0; step < phase_items[phase]; step++)
            begin
                if (step == 10 || $urandom_range(0, 29) == 0)
                    hold_until_empty();
                if ($urandom_range(0, 99) < 40)
                    store_entry(($urandom_range(0, 99) < 70) ? 9'($urandom_range(0, span - 1))
                                                              : 9'($urandom),
                                random_color(), 8'($urandom), 8'($urandom));
                else
                    ask_nearest(random_color());
            end
        end
        steady = 1'b0;

        // Drain, wait idle, then report the verdict
        hold_until_empty();
        repeat (PALETTE_DEPTH + 16) @(posedge clk);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/nps_pkg.sv
sv/nps_ram.sv
sv/nps_dist.sv
sv/nearest_palette_color_search.sv
tb/palette_match_checker.sv
tb/testbench.sv
